// ----- rtl/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
// No dependencies; used by every module of the block.
`default_nettype none

package tcw_pkg;

  localparam int SCREEN_WIDTH_DEF  = 80;
  localparam int SCREEN_HEIGHT_DEF = 25;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;
  localparam int CELL_W      = 16;
  localparam int INDEX_W     = 11;

  localparam logic [1:0] MODE_PRINT = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;

  localparam logic [CELL_W-1:0] BLANK_SCROLL = 16'h0F20;
  localparam logic [CELL_W-1:0] BLANK_CLEAR  = 16'h0720;

  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_PUT   = 3'd1,
    OP_CR    = 3'd2,
    OP_LF    = 3'd3,
    OP_CLEAR = 3'd4,
    OP_READ  = 3'd5
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [7:0]         char_code;
    logic [7:0]         attr;
    logic [INDEX_W-1:0] cell_index;
  } cmd_t;

  // first member sits in the highest bits: cursor row ends up in the lowest
  typedef struct packed {
    logic              scrolled;
    logic [CELL_W-1:0] cell_data;
    logic [11:0]       cursor_position;
    logic [6:0]        cursor_col_out;
    logic [4:0]        cursor_row_out;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/tcw_front.sv -----
// Input stage: accepts stream transfers, decodes them into commands.
// Depends on tcw_pkg; feeds tcw_queue.
`default_nettype none

module tcw_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [tcw_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic [tcw_pkg::IN_TUSER_W-1:0] in_tuser,
  input  wire logic                           init_done,
  input  wire logic                           q_full,
  output logic                                push,
  output tcw_pkg::cmd_t                       push_cmd
);
  import tcw_pkg::*;

  logic vld_r, vld_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic accept;
  logic [7:0] ch;

  assign push      = vld_r && !q_full;
  assign in_tready = init_done && (!vld_r || !q_full);
  assign accept    = in_tvalid && in_tready;
  assign push_cmd  = cmd_r;
  assign ch        = in_tdata[7:0];

  always_comb begin
    cmd_nxt            = cmd_r;
    vld_nxt            = vld_r && !push;
    if (accept) begin
      vld_nxt            = 1'b1;
      cmd_nxt.char_code  = ch;
      cmd_nxt.attr       = {in_tdata[15:12], in_tdata[11:8]};
      cmd_nxt.cell_index = in_tdata[26:16];
      case (in_tuser)
        MODE_PRINT: begin
          if (ch == CHAR_CR) begin
            cmd_nxt.op = OP_CR;
          end else if (ch == CHAR_LF) begin
            cmd_nxt.op = OP_LF;
          end else begin
            cmd_nxt.op = OP_PUT;
          end
        end
        MODE_CLEAR: cmd_nxt.op = OP_CLEAR;
        MODE_READ:  cmd_nxt.op = OP_READ;
        default:    cmd_nxt.op = OP_NOP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/tcw_queue.sv -----
// Short command FIFO between decode and execution.
// Depends on tcw_pkg for the command type.
`default_nettype none

module tcw_queue #(
  parameter int DEPTH = tcw_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tcw_pkg::cmd_t push_cmd,
  output logic               full,
  output logic               q_valid,
  output tcw_pkg::cmd_t      q_cmd,
  input  wire logic          pop
);
  import tcw_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tcw_back.sv -----
// Execution engine: cursor, screen memory and the fill/scroll sequencer,
// plus the result register. Depends on tcw_pkg.
`default_nettype none

module tcw_back #(
  parameter int SCREEN_WIDTH  = tcw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tcw_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire tcw_pkg::cmd_t q_cmd,
  output logic               q_pop,
  output logic               init_done,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tcw_pkg::res_t      out_res
);
  import tcw_pkg::*;

  localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int NW         = $clog2(CELL_COUNT + 1);
  localparam int RW         = $clog2(SCREEN_HEIGHT);
  localparam int RW1        = RW + 1;
  localparam int CW         = $clog2(SCREEN_WIDTH + 1);
  localparam int COPY_N     = (SCREEN_HEIGHT - 2) * SCREEN_WIDTH;
  localparam int FILL_N     = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH;

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_COPY   = 7'b0000100,
    S_BLANK  = 7'b0001000,
    S_FILL   = 7'b0010000,
    S_READ   = 7'b0100000,
    S_RESULT = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [NW-1:0]     k_r, k_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic              scroll_r, scroll_nxt;
  logic [CELL_W-1:0] data_r, data_nxt;
  logic              oob_r, oob_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r, out_res_nxt;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rdata_r;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [CELL_W-1:0] wdata;
  logic [AW-1:0]     raddr;

  logic [RW1-1:0]    row_inc;
  logic [CW-1:0]     col_base;
  logic [CW-1:0]     col_inc;
  logic [AW-1:0]     put_addr;
  logic              hit_bottom;
  logic              slot_free;

  assign init_done = (state_r != S_INIT);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    row_inc    = {1'b0, row_r} + 1'b1;
    col_base   = (col_r >= CW'(SCREEN_WIDTH)) ? '0 : col_r;
    col_inc    = col_base + 1'b1;
    put_addr   = AW'(row_r) * AW'(SCREEN_WIDTH) + AW'(col_base);
    hit_bottom = (row_inc >= RW1'(SCREEN_HEIGHT));
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    scroll_nxt    = scroll_r;
    data_nxt      = data_r;
    oob_nxt       = oob_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    raddr         = '0;
    case (state_r)
      S_INIT: begin
        we    = 1'b1;
        waddr = AW'(k_r);
        if (k_r == NW'(CELL_COUNT - 1)) begin
          k_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_IDLE: begin
        raddr = AW'(q_cmd.cell_index);
        if (q_valid) begin
          q_pop      = 1'b1;
          scroll_nxt = 1'b0;
          data_nxt   = '0;
          k_nxt      = '0;
          state_nxt  = S_RESULT;
          case (q_cmd.op)
            OP_PUT: begin
              we    = 1'b1;
              waddr = put_addr;
              wdata = {q_cmd.attr, q_cmd.char_code};
              if (col_inc == CW'(SCREEN_WIDTH)) begin
                if (hit_bottom) begin
                  scroll_nxt = 1'b1;
                  row_nxt    = RW'(SCREEN_HEIGHT - 1);
                  col_nxt    = '0;
                  state_nxt  = S_COPY;
                end else begin
                  row_nxt = row_inc[RW-1:0];
                  col_nxt = col_inc;
                end
              end else begin
                col_nxt = col_inc;
              end
            end
            OP_CR: col_nxt = '0;
            OP_LF: begin
              col_nxt = '0;
              if (hit_bottom) begin
                scroll_nxt = 1'b1;
                row_nxt    = RW'(SCREEN_HEIGHT - 1);
                state_nxt  = S_COPY;
              end else begin
                row_nxt = row_inc[RW-1:0];
              end
            end
            OP_CLEAR: begin
              row_nxt   = RW'(1);
              col_nxt   = '0;
              state_nxt = S_FILL;
            end
            OP_READ: begin
              oob_nxt   = !(32'(q_cmd.cell_index) < 32'(CELL_COUNT));
              state_nxt = S_READ;
            end
            default: ;
          endcase
        end
      end
      // read runs one cell ahead of the write, a row apart
      S_COPY: begin
        if (k_r < NW'(COPY_N)) begin
          raddr = AW'(2 * SCREEN_WIDTH) + AW'(k_r);
        end
        if (k_r != '0) begin
          we    = 1'b1;
          waddr = AW'(SCREEN_WIDTH) + AW'(k_r) - AW'(1);
          wdata = rdata_r;
        end
        if (k_r == NW'(COPY_N)) begin
          k_nxt     = '0;
          state_nxt = S_BLANK;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_BLANK: begin
        we    = 1'b1;
        waddr = AW'(FILL_N) + AW'(k_r);
        wdata = BLANK_SCROLL;
        if (k_r == NW'(SCREEN_WIDTH - 1)) begin
          state_nxt = S_RESULT;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_FILL: begin
        we    = 1'b1;
        waddr = AW'(SCREEN_WIDTH) + AW'(k_r);
        wdata = BLANK_CLEAR;
        if (k_r == NW'(FILL_N - 1)) begin
          state_nxt = S_RESULT;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_READ: begin
        data_nxt  = oob_r ? '0 : rdata_r;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (slot_free) begin
          out_valid_nxt               = 1'b1;
          out_res_nxt.scrolled        = scroll_r;
          out_res_nxt.cell_data       = data_r;
          out_res_nxt.cursor_position =
            12'(NW'(row_r) * NW'(SCREEN_WIDTH) + NW'(col_r));
          out_res_nxt.cursor_col_out  = 7'(col_r);
          out_res_nxt.cursor_row_out  = 5'(row_r);
          state_nxt                   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      k_r         <= '0;
      row_r       <= RW'(1);
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scroll_r  <= scroll_nxt;
    data_r    <= data_nxt;
    oob_r     <= oob_nxt;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  a_pending_row: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r == CW'(SCREEN_WIDTH)) |-> (row_r >= RW'(2)))
    else $error("wrap pending on a row that cannot follow a write");

  a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && slot_free) |=> out_valid_r)
    else $error("result not presented");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r != S_IDLE))
    else $error("command popped without execution");

  a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) |-> (k_r <= NW'(COPY_N)))
    else $error("scroll copy ran past its end");

endmodule

`default_nettype wire

// ----- rtl/text_console_writer_top.sv -----
// Top level of the text console writer: decode, command queue, execution.
// Depends on tcw_pkg, tcw_front, tcw_queue, tcw_back.
// Print, CR, LF: registered in cmd_r, queued, popped (S_IDLE), then loaded
// the result register (S_RESULT), a read via S_READ; commands run one by one.
// Scroll adds an S_COPY row copy and an S_BLANK row fill; clear adds S_FILL.
// After reset the screen memory is zeroed, input held off.
`default_nettype none

module text_console_writer_top #(
  parameter int SCREEN_WIDTH  = tcw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tcw_pkg::SCREEN_HEIGHT_DEF,
  parameter int QUEUE_DEPTH   = tcw_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // char_code[7:0], fore_colour[11:8], back_colour[15:12], cell_index[26:16]
  input  wire logic [tcw_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode[1:0]
  input  wire logic [tcw_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // cursor_row_out[4:0], cursor_col_out[11:5], cursor_position[23:12],
  // cell_data[39:24], scrolled[40]
  output logic [tcw_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import tcw_pkg::*;

  logic init_done;
  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;
  res_t out_res;

  tcw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .init_done (init_done),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  tcw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (q_pop)
  );

  tcw_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .init_done (init_done),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = OUT_TDATA_W'(out_res);

endmodule

`default_nettype wire

// ----- tb/text_console_writer_top_test.sv -----
// Stream-level test of text_console_writer_top: directed command table, then random traffic.
// Results are checked against typed values, else a cycle-free console predictor kept here.
// Depends on tcw_pkg and the text_console_writer_top RTL only.
`timescale 1ns / 1ps

module text_console_writer_top_test;
  import tcw_pkg::*;

  localparam int W            = SCREEN_WIDTH_DEF;
  localparam int H            = SCREEN_HEIGHT_DEF;
  localparam int CELLS        = W * H;
  localparam int RANDOM_ITEMS = 1150;
  localparam int STALL_LIMIT  = 20000;
  localparam logic [1:0] MODE_NONE = 2'd3;
  // {scrolled, cell_data, cursor_position, cursor_col_out, cursor_row_out}
  localparam res_t HOME = {1'b0, 16'h0000, 12'd80, 7'd0, 5'd1};

  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  ch;
    logic [3:0]  fg;
    logic [3:0]  bg;
    logic [10:0] idx;
    int          reps;
    bit          known;
    res_t        want;
  } console_vec_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // char_code[7:0], fore_colour[11:8], back_colour[15:12], cell_index[26:16]
  logic [IN_TDATA_W-1:0]  in_tdata;
  // mode[1:0]
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  // cursor_row_out[4:0], cursor_col_out[11:5], cursor_position[23:12],
  // cell_data[39:24], scrolled[40]
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [15:0]  screen_mem [CELLS];
  int           crsr_row;
  int           crsr_col;
  res_t         reports_due[$];
  console_vec_t dir_vecs[$];
  int           fail_count = 0;
  bit           steady     = 1'b0;
  bit           hold_req   = 1'b0;

  text_console_writer_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void scroll_screen();
    for (int i = W; i < (H - 1) * W; i++) screen_mem[i] = screen_mem[i + W];
    for (int i = (H - 1) * W; i < CELLS; i++) screen_mem[i] = BLANK_SCROLL;
  endfunction

  function automatic res_t apply_console_cmd(logic [1:0] mode, logic [7:0] ch,
                                             logic [3:0] fg, logic [3:0] bg,
                                             logic [10:0] idx);
    res_t r;
    bit   ctl;
    r   = '0;
    ctl = (ch == CHAR_CR) || (ch == CHAR_LF);
    case (mode)
      MODE_PRINT: begin
        if (crsr_col >= W || ctl) crsr_col = 0;
        if (ch == CHAR_LF) crsr_row++;
        if (crsr_row > H - 1) begin
          scroll_screen();
          r.scrolled = 1'b1;
          crsr_row   = H - 1;
        end
        if (!ctl) begin
          screen_mem[crsr_row * W + crsr_col] = {bg, fg, ch};
          crsr_col++;
          if (crsr_col == W) begin
            crsr_row++;
            if (crsr_row >= H) begin
              scroll_screen();
              r.scrolled = 1'b1;
              crsr_row   = H - 1;
              crsr_col   = 0;
            end
          end
        end
      end
      MODE_CLEAR: begin
        for (int i = W; i < CELLS; i++) screen_mem[i] = BLANK_CLEAR;
        crsr_row = 1;
        crsr_col = 0;
      end
      MODE_READ: begin
        if (idx < CELLS) r.cell_data = screen_mem[idx];
      end
      default: ;
    endcase
    r.cursor_row_out  = 5'(crsr_row);
    r.cursor_col_out  = 7'(crsr_col);
    r.cursor_position = 12'(crsr_row * W + crsr_col);
    return r;
  endfunction

  function automatic void add_vec(logic [1:0] mode, logic [7:0] ch, logic [3:0] fg,
                                  logic [3:0] bg, logic [10:0] idx, int reps,
                                  bit known, res_t want);
    console_vec_t v;
    v.mode  = mode;
    v.ch    = ch;
    v.fg    = fg;
    v.bg    = bg;
    v.idx   = idx;
    v.reps  = reps;
    v.known = known;
    v.want  = want;
    dir_vecs.push_back(v);
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Drives one command at the falling edge and holds it until the transfer.
  task automatic send_cmd(input logic [1:0] mode, input logic [7:0] ch, input logic [3:0] fg,
                          input logic [3:0] bg, input logic [10:0] idx, input bit known,
                          input res_t want);
    res_t pred;
    while (!steady && $urandom_range(0, 99) < 18) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = {5'b0, idx, bg, fg, ch};
    do @(posedge clk); while (!in_tready);
    pred = apply_console_cmd(mode, ch, fg, bg, idx);
    reports_due.push_back(known ? want : pred);
    @(negedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = steady || ($urandom_range(0, 99) >= 18);
      end
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[40:0];
      if (reports_due.size() == 0) begin
        $error("result transfer with no command pending: 0x%0h", out_tdata);
        fail_count++;
      end else begin
        want = reports_due.pop_front();
        check_field("cursor_row_out", 16'(want.cursor_row_out), 16'(got.cursor_row_out));
        check_field("cursor_col_out", 16'(want.cursor_col_out), 16'(got.cursor_col_out));
        check_field("cursor_position", 16'(want.cursor_position), 16'(got.cursor_position));
        check_field("cell_data", want.cell_data, got.cell_data);
        check_field("scrolled", 16'(want.scrolled), 16'(got.scrolled));
        check_field("out_tdata padding", 16'h0, 16'(out_tdata[OUT_TDATA_W-1:41]));
      end
    end
  end

  // Ends the run when no transfer happens on either side for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("text_console_writer_top test failed");
    $finish;
  end

  initial begin
    console_vec_t v;
    logic [1:0]   mode;
    logic [7:0]   ch;
    logic [3:0]   fg;
    logic [3:0]   bg;
    logic [10:0]  idx;
    int           pick;
    int           sel;
    int           lf_pct;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    foreach (screen_mem[i]) screen_mem[i] = '0;
    crsr_row = 1;
    crsr_col = 0;
    lf_pct   = 12;

    // mode, char, fore, back, cell index, repeat, typed, expected
    add_vec(MODE_READ,  8'h00, 4'h0, 4'h0, 11'd0,    1, 1, HOME);
    add_vec(MODE_READ,  8'hFF, 4'hF, 4'hF, 11'd1999, 1, 1, HOME);
    add_vec(MODE_READ,  8'h00, 4'h0, 4'h0, 11'd2047, 1, 1, HOME);  // beyond the screen
    add_vec(MODE_NONE,  8'hFF, 4'hF, 4'hF, 11'd2047, 1, 1, HOME);
    add_vec(MODE_PRINT, 8'h41, 4'hF, 4'hF, 11'd0,    1, 1, {1'b0, 16'h0, 12'd81, 7'd1, 5'd1});
    add_vec(MODE_PRINT, 8'h00, 4'h0, 4'h0, 11'd2047, 1, 0, '0);
    add_vec(MODE_PRINT, 8'hFF, 4'hF, 4'h0, 11'd0,    1, 0, '0);
    add_vec(MODE_READ,  8'h00, 4'h0, 4'h0, 11'd80,   1, 1,
            {1'b0, 16'hFF41, 12'd83, 7'd3, 5'd1});
    add_vec(MODE_READ,  8'h00, 4'h0, 4'h0, 11'd82,   1, 1,
            {1'b0, 16'h0FFF, 12'd83, 7'd3, 5'd1});
    add_vec(MODE_PRINT, CHAR_CR, 4'hF, 4'hF, 11'd0,  1, 1, HOME);
    add_vec(MODE_PRINT, CHAR_LF, 4'hA, 4'h5, 11'd0,  1, 1, {1'b0, 16'h0, 12'd160, 7'd0, 5'd2});
    add_vec(MODE_CLEAR, 8'h55, 4'h5, 4'hA, 11'd1234, 1, 1, HOME);
    add_vec(MODE_READ,  8'h00, 4'h0, 4'h0, 11'd80,   1, 1,
            {1'b0, BLANK_CLEAR, 12'd80, 7'd0, 5'd1});
    add_vec(MODE_READ,  8'h00, 4'h0, 4'h0, 11'd1999, 1, 1,
            {1'b0, BLANK_CLEAR, 12'd80, 7'd0, 5'd1});
    add_vec(MODE_READ,  8'h00, 4'h0, 4'h0, 11'd0,    1, 1, HOME);  // reserved row untouched
    add_vec(MODE_PRINT, 8'h78, 4'h2, 4'h1, 11'd0,    W, 0, '0);    // full row, wrap pending
    add_vec(MODE_READ,  8'h00, 4'h0, 4'h0, 11'd159,  1, 1,
            {1'b0, 16'h1278, 12'd240, 7'd80, 5'd2});
    add_vec(MODE_PRINT, 8'h79, 4'h3, 4'h4, 11'd0,    1, 0, '0);
    add_vec(MODE_PRINT, CHAR_LF, 4'h0, 4'h0, 11'd0,  22, 0, '0);   // down to the last row
    add_vec(MODE_PRINT, CHAR_LF, 4'h0, 4'h0, 11'd0,  1, 1, {1'b1, 16'h0, 12'd1920, 7'd0, 5'd24});
    add_vec(MODE_READ,  8'h00, 4'h0, 4'h0, 11'd1920, 1, 1,
            {1'b0, BLANK_SCROLL, 12'd1920, 7'd0, 5'd24});
    add_vec(MODE_READ,  8'h00, 4'h0, 4'h0, 11'd1840, 1, 1,
            {1'b0, BLANK_CLEAR, 12'd1920, 7'd0, 5'd24});
    add_vec(MODE_READ,  8'h00, 4'h0, 4'h0, 11'd80,   1, 1,
            {1'b0, 16'h4379, 12'd1920, 7'd0, 5'd24});
    add_vec(MODE_PRINT, 8'h71, 4'hE, 4'h9, 11'd0,    W, 0, '0);    // wrap on the last row
    add_vec(MODE_READ,  8'h00, 4'h0, 4'h0, 11'd1840, 1, 0, '0);

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_vecs[k]) begin
      v = dir_vecs[k];
      for (int r = 0; r < v.reps; r++) send_cmd(v.mode, v.ch, v.fg, v.bg, v.idx, v.known, v.want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // some stretches carry long unbroken lines so wraps happen
      if (n % 100 == 0) lf_pct = ($urandom_range(0, 2) == 0) ? 0 : 12;
      steady = (n >= 500 && n < 700);
      if (n == 150) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      ch   = 8'($urandom_range(0, 255));
      fg   = 4'($urandom_range(0, 15));
      bg   = 4'($urandom_range(0, 15));
      idx  = 11'($urandom_range(0, 2047));
      if (pick < 2) begin
        mode = MODE_CLEAR;
      end else if (pick < 4) begin
        mode = MODE_NONE;
      end else if (pick < 30) begin
        mode = MODE_READ;
        if ($urandom_range(0, 1) == 1)
          idx = 11'((crsr_row - $urandom_range(0, 1)) * W + $urandom_range(0, W - 1));
      end else begin
        mode = MODE_PRINT;
        sel  = $urandom_range(0, 99);
        if (sel < lf_pct) ch = CHAR_LF;
        else if (lf_pct != 0 && sel < lf_pct + 3) ch = CHAR_CR;
      end
      send_cmd(mode, ch, fg, bg, idx, 1'b0, '0);
    end

    in_tvalid = 1'b0;
    steady    = 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (fail_count == 0) begin
      $display("text_console_writer_top test passed");
    end else begin
      $display("text_console_writer_top test failed");
    end
    $finish;
  end

endmodule
